>>> sv/itst_pkg.sv
`timescale 1ns / 1ps

package itst_pkg;

  localparam int unsigned SEC_W  = 32;
  localparam int unsigned NSEC_W = 30;
  localparam int unsigned ID_W   = 5;

  localparam logic [NSEC_W-1:0] NS_MAX     = NSEC_W'(999999999);
  localparam logic [NSEC_W:0]   NS_PER_SEC = 31'd1000000000;
  localparam logic [SEC_W-1:0]  NO_MIN_SEC = 32'd99999999;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_START = 2'd1;
  localparam logic [1:0] ERR_STOP  = 2'd2;

  typedef struct packed {
    logic              active;
    logic [SEC_W-1:0]  start_sec;
    logic [NSEC_W-1:0] start_nsec;
    logic [SEC_W-1:0]  total_sec;
    logic [NSEC_W-1:0] total_nsec;
    logic [SEC_W-1:0]  min_sec;
    logic [NSEC_W-1:0] min_nsec;
    logic [SEC_W-1:0]  max_sec;
    logic [NSEC_W-1:0] max_nsec;
    logic [31:0]       count;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    active:     1'b0,
    start_sec:  '0,
    start_nsec: '0,
    total_sec:  '0,
    total_nsec: '0,
    min_sec:    NO_MIN_SEC,
    min_nsec:   '0,
    max_sec:    '0,
    max_nsec:   '0,
    count:      '0
  };

  typedef struct packed {
    logic load;
    logic rd;
    logic iv;
    logic wb;
  } cmd_t;

endpackage

>>> sv/itst_ctrl.sv
`timescale 1ns / 1ps

module itst_ctrl import itst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_IV   = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_IV;
      end
      S_IV: begin
        cmd_o.iv = 1'b1;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> sv/itst_dp.sv
`timescale 1ns / 1ps

module itst_dp import itst_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [1:0]        func_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [SEC_W-1:0]  now_sec_i,
  input  logic [NSEC_W-1:0] now_nsec_i,
  output logic              done_o,
  output logic [1:0]        error_code_o,
  output logic              active_o,
  output logic [31:0]       call_count_o,
  output logic [SEC_W-1:0]  total_sec_o,
  output logic [NSEC_W-1:0] total_nsec_o,
  output logic [SEC_W-1:0]  min_sec_o,
  output logic [NSEC_W-1:0] min_nsec_o,
  output logic [SEC_W-1:0]  max_sec_o,
  output logic [NSEC_W-1:0] max_nsec_o,
  output logic [SEC_W-1:0]  interval_sec_o,
  output logic [NSEC_W-1:0] interval_nsec_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // latched beat
  logic [1:0]        func_q;
  logic [IDX_W-1:0]  idx_q;
  logic              rng_q;
  logic [SEC_W-1:0]  now_s_q;
  logic [NSEC_W-1:0] now_n_q;

  entry_t            mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_q;

  entry_t            rd_q;
  logic              rd_vld_q;
  entry_t            ent_q;
  logic [SEC_W-1:0]  iv_s_q;
  logic [NSEC_W-1:0] iv_n_q;

  logic done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      idx_q   <= IDX_W'(timer_id_i);
      rng_q   <= ({4'd0, timer_id_i} < 9'(NUM_TIMERS));
      now_s_q <= now_sec_i;
      now_n_q <= (now_nsec_i > NS_MAX) ? NS_MAX : now_nsec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q];
    end
  end

  // interval stage
  entry_t            ent;
  logic [NSEC_W:0]   ndiff;
  logic              borrow;

  always_comb begin
    ent    = rd_vld_q ? rd_q : RESET_ENTRY;
    ndiff  = {1'b0, now_n_q} - {1'b0, ent.start_nsec};
    borrow = ndiff[NSEC_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iv) begin
      ent_q  <= ent;
      iv_s_q <= now_s_q - ent.start_sec - SEC_W'(borrow);
      iv_n_q <= borrow ? NSEC_W'(ndiff + NS_PER_SEC) : ndiff[NSEC_W-1:0];
    end
  end

  // update stage
  entry_t            upd;
  logic [1:0]        err;
  logic              wr;
  logic [NSEC_W:0]   tn_raw;
  logic              carry;
  logic [SEC_W:0]    wide;
  logic [NSEC_W-1:0] tn;
  logic              min_lt_iv;
  logic              iv_lt_max;

  always_comb begin
    tn_raw    = {1'b0, ent_q.total_nsec} + {1'b0, iv_n_q};
    carry     = (tn_raw >= NS_PER_SEC);
    tn        = carry ? NSEC_W'(tn_raw - NS_PER_SEC) : tn_raw[NSEC_W-1:0];
    wide      = {1'b0, ent_q.total_sec} + {1'b0, iv_s_q} + (SEC_W+1)'(carry);
    min_lt_iv = (ent_q.min_sec < iv_s_q) ||
                ((ent_q.min_sec == iv_s_q) && (ent_q.min_nsec < iv_n_q));
    iv_lt_max = (iv_s_q < ent_q.max_sec) ||
                ((iv_s_q == ent_q.max_sec) && (iv_n_q < ent_q.max_nsec));

    upd = ent_q;
    err = ERR_OK;
    wr  = 1'b0;
    unique case (func_q)
      FUNC_CLEAR: upd = RESET_ENTRY;
      FUNC_START: begin
        if (ent_q.active) begin
          err = ERR_START;
        end else begin
          upd.active     = 1'b1;
          upd.start_sec  = now_s_q;
          upd.start_nsec = now_n_q;
          wr             = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (!ent_q.active) begin
          err = ERR_STOP;
        end else begin
          upd.active = 1'b0;
          if (wide[SEC_W]) begin
            upd.total_sec  = '1;
            upd.total_nsec = NS_MAX;
          end else begin
            upd.total_sec  = wide[SEC_W-1:0];
            upd.total_nsec = tn;
          end
          if (!min_lt_iv) begin
            upd.min_sec  = iv_s_q;
            upd.min_nsec = iv_n_q;
          end
          if (!iv_lt_max) begin
            upd.max_sec  = iv_s_q;
            upd.max_nsec = iv_n_q;
          end
          if (ent_q.count != '1) begin
            upd.count = ent_q.count + 32'd1;
          end
          wr = 1'b1;
        end
      end
      FUNC_READ: upd = ent_q;
      default:   upd = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && rng_q && wr) begin
      mem[idx_q] <= upd;
    end
  end

  // invalid entries read back as the reset entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.wb;
      if (cmd_i.rd) begin
        rd_vld_q <= rng_q && vld_q[idx_q];
      end
      if (cmd_i.wb && rng_q) begin
        if (func_q == FUNC_CLEAR) begin
          vld_q[idx_q] <= 1'b0;
        end else if (wr) begin
          vld_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      if (rng_q) begin
        error_code_o    <= err;
        active_o        <= upd.active;
        call_count_o    <= upd.count;
        total_sec_o     <= upd.total_sec;
        total_nsec_o    <= upd.total_nsec;
        min_sec_o       <= upd.min_sec;
        min_nsec_o      <= upd.min_nsec;
        max_sec_o       <= upd.max_sec;
        max_nsec_o      <= upd.max_nsec;
        interval_sec_o  <= (func_q == FUNC_STOP && err == ERR_OK) ? iv_s_q : '0;
        interval_nsec_o <= (func_q == FUNC_STOP && err == ERR_OK) ? iv_n_q : '0;
      end else begin
        error_code_o    <= ERR_OK;
        active_o        <= 1'b0;
        call_count_o    <= '0;
        total_sec_o     <= '0;
        total_nsec_o    <= '0;
        min_sec_o       <= '0;
        min_nsec_o      <= '0;
        max_sec_o       <= '0;
        max_nsec_o      <= '0;
        interval_sec_o  <= '0;
        interval_nsec_o <= '0;
      end
    end
  end

  assign done_o = done_q;

endmodule

>>> sv/interval_timer_stats_table.sv
`timescale 1ns / 1ps
// done_o pulses after the beat passes the read, interval and update states
// a new beat is taken only from idle, after the read / interval / update pass
// over the single-port entry memory; busy_o is high during that pass
// reset: all entries read as cleared (valid bits drop at once), no sweep needed
// done_o is a one-cycle pulse, the receiver cannot stall it

module interval_timer_stats_table import itst_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        func_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [SEC_W-1:0]  now_sec_i,
  input  logic [NSEC_W-1:0] now_nsec_i,
  output logic              done_o,
  output logic [1:0]        error_code_o,
  output logic              active_o,
  output logic [31:0]       call_count_o,
  output logic [SEC_W-1:0]  total_sec_o,
  output logic [NSEC_W-1:0] total_nsec_o,
  output logic [SEC_W-1:0]  min_sec_o,
  output logic [NSEC_W-1:0] min_nsec_o,
  output logic [SEC_W-1:0]  max_sec_o,
  output logic [NSEC_W-1:0] max_nsec_o,
  output logic [SEC_W-1:0]  interval_sec_o,
  output logic [NSEC_W-1:0] interval_nsec_o
);

  cmd_t cmd;

  itst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  itst_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .timer_id_i      (timer_id_i),
    .now_sec_i       (now_sec_i),
    .now_nsec_i      (now_nsec_i),
    .done_o          (done_o),
    .error_code_o    (error_code_o),
    .active_o        (active_o),
    .call_count_o    (call_count_o),
    .total_sec_o     (total_sec_o),
    .total_nsec_o    (total_nsec_o),
    .min_sec_o       (min_sec_o),
    .min_nsec_o      (min_nsec_o),
    .max_sec_o       (max_sec_o),
    .max_nsec_o      (max_nsec_o),
    .interval_sec_o  (interval_sec_o),
    .interval_nsec_o (interval_nsec_o)
  );

endmodule

>>> tb/tb_interval_timer_stats_table.sv
`timescale 1ns / 1ps

module tb_interval_timer_stats_table;
  import itst_pkg::*;

  localparam int unsigned NUM_TIMERS = 32;
  localparam int unsigned N_RANDOM   = 1680;
  localparam int unsigned N_CALM     = 200;

  typedef struct {
    logic [1:0]        err;
    logic              active;
    logic [31:0]       count;
    logic [SEC_W-1:0]  tot_s;
    logic [NSEC_W-1:0] tot_n;
    logic [SEC_W-1:0]  min_s;
    logic [NSEC_W-1:0] min_n;
    logic [SEC_W-1:0]  max_s;
    logic [NSEC_W-1:0] max_n;
    logic [SEC_W-1:0]  iv_s;
    logic [NSEC_W-1:0] iv_n;
  } stats_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic [1:0]        func_i     = FUNC_READ;
  logic [ID_W-1:0]   timer_id_i = '0;
  logic [SEC_W-1:0]  now_sec_i  = '0;
  logic [NSEC_W-1:0] now_nsec_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        error_code_o;
  logic              active_o;
  logic [31:0]       call_count_o;
  logic [SEC_W-1:0]  total_sec_o;
  logic [NSEC_W-1:0] total_nsec_o;
  logic [SEC_W-1:0]  min_sec_o;
  logic [NSEC_W-1:0] min_nsec_o;
  logic [SEC_W-1:0]  max_sec_o;
  logic [NSEC_W-1:0] max_nsec_o;
  logic [SEC_W-1:0]  interval_sec_o;
  logic [NSEC_W-1:0] interval_nsec_o;

  entry_t      timer_tbl [NUM_TIMERS];
  stats_t      pending_stats [$];
  bit          gaps_on = 1'b1;
  int unsigned n_beats, n_measured, n_misuse, n_checked, n_fail;

  interval_timer_stats_table #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .timer_id_i     (timer_id_i),
    .now_sec_i      (now_sec_i),
    .now_nsec_i     (now_nsec_i),
    .done_o         (done_o),
    .error_code_o   (error_code_o),
    .active_o       (active_o),
    .call_count_o   (call_count_o),
    .total_sec_o    (total_sec_o),
    .total_nsec_o   (total_nsec_o),
    .min_sec_o      (min_sec_o),
    .min_nsec_o     (min_nsec_o),
    .max_sec_o      (max_sec_o),
    .max_nsec_o     (max_nsec_o),
    .interval_sec_o (interval_sec_o),
    .interval_nsec_o(interval_nsec_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit stamp_lt(logic [SEC_W-1:0] a_s, logic [NSEC_W-1:0] a_n,
                                  logic [SEC_W-1:0] b_s, logic [NSEC_W-1:0] b_n);
    return (a_s != b_s) ? (a_s < b_s) : (a_n < b_n);
  endfunction

  // applies one command to the shadow table, returns the entry as the block reports it
  function automatic stats_t apply_timer_cmd(logic [1:0] fn, logic [ID_W-1:0] id,
                                             logic [SEC_W-1:0] s, logic [NSEC_W-1:0] ns_in);
    stats_t            r;
    entry_t            e;
    logic [NSEC_W-1:0] ns;
    logic [SEC_W-1:0]  iv_s;
    logic [31:0]       iv_n;
    logic [31:0]       tn;
    logic [SEC_W:0]    wide;
    r    = '{default: '0};
    iv_s = '0;
    iv_n = '0;
    ns   = (ns_in > NS_MAX) ? NS_MAX : ns_in;
    if (32'(id) >= NUM_TIMERS) return r;
    e = timer_tbl[id];
    case (fn)
      FUNC_CLEAR: e = RESET_ENTRY;
      FUNC_START: begin
        if (e.active) begin
          r.err = ERR_START;
          n_misuse++;
        end else begin
          e.active     = 1'b1;
          e.start_sec  = s;
          e.start_nsec = ns;
        end
      end
      FUNC_STOP: begin
        if (!e.active) begin
          r.err = ERR_STOP;
          n_misuse++;
        end else begin
          // borrow one second when the nanoseconds went backwards
          if (ns < e.start_nsec) begin
            iv_s = s - e.start_sec - 32'd1;
            iv_n = 32'(NS_PER_SEC) + 32'(ns) - 32'(e.start_nsec);
          end else begin
            iv_s = s - e.start_sec;
            iv_n = 32'(ns) - 32'(e.start_nsec);
          end
          tn   = 32'(e.total_nsec) + iv_n;
          wide = {1'b0, e.total_sec} + {1'b0, iv_s};
          if (tn >= 32'(NS_PER_SEC)) begin
            tn   = tn - 32'(NS_PER_SEC);
            wide = wide + (SEC_W+1)'(1);
          end
          if (wide[SEC_W]) begin
            e.total_sec  = '1;
            e.total_nsec = NS_MAX;
          end else begin
            e.total_sec  = wide[SEC_W-1:0];
            e.total_nsec = tn[NSEC_W-1:0];
          end
          if (!stamp_lt(e.min_sec, e.min_nsec, iv_s, iv_n[NSEC_W-1:0])) begin
            e.min_sec  = iv_s;
            e.min_nsec = iv_n[NSEC_W-1:0];
          end
          if (!stamp_lt(iv_s, iv_n[NSEC_W-1:0], e.max_sec, e.max_nsec)) begin
            e.max_sec  = iv_s;
            e.max_nsec = iv_n[NSEC_W-1:0];
          end
          if (e.count != '1) e.count = e.count + 32'd1;
          e.active = 1'b0;
          n_measured++;
        end
      end
      default: ;
    endcase
    timer_tbl[id] = e;
    r.active = e.active;
    r.count  = e.count;
    r.tot_s  = e.total_sec;
    r.tot_n  = e.total_nsec;
    r.min_s  = e.min_sec;
    r.min_n  = e.min_nsec;
    r.max_s  = e.max_sec;
    r.max_n  = e.max_nsec;
    r.iv_s   = iv_s;
    r.iv_n   = iv_n[NSEC_W-1:0];
    return r;
  endfunction

  function automatic logic [NSEC_W-1:0] rand_nsec();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return NS_MAX;
      2:       return NSEC_W'($urandom_range(32'd1000000000, 32'h3FFF_FFFF));
      default: return NSEC_W'($urandom_range(0, 999999999));
    endcase
  endfunction

  task automatic send_cmd(logic [1:0] fn, logic [ID_W-1:0] id,
                          logic [SEC_W-1:0] s, logic [NSEC_W-1:0] ns);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    func_i     <= fn;
    timer_id_i <= id;
    now_sec_i  <= s;
    now_nsec_i <= ns;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_stats.push_back(apply_timer_cmd(fn, id, s, ns));
    n_beats++;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_stats.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        want = pending_stats.pop_front();
        n_checked++;
        check_field("error_code", 64'(want.err), 64'(error_code_o));
        check_field("active", 64'(want.active), 64'(active_o));
        check_field("call_count", 64'(want.count), 64'(call_count_o));
        check_field("total_sec", 64'(want.tot_s), 64'(total_sec_o));
        check_field("total_nsec", 64'(want.tot_n), 64'(total_nsec_o));
        check_field("min_sec", 64'(want.min_s), 64'(min_sec_o));
        check_field("min_nsec", 64'(want.min_n), 64'(min_nsec_o));
        check_field("max_sec", 64'(want.max_s), 64'(max_sec_o));
        check_field("max_nsec", 64'(want.max_n), 64'(max_nsec_o));
        check_field("interval_sec", 64'(want.iv_s), 64'(interval_sec_o));
        check_field("interval_nsec", 64'(want.iv_n), 64'(interval_nsec_o));
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(FUNC_READ, 5'd0, '0, '0);
    send_cmd(FUNC_READ, 5'd31, '1, NS_MAX);
  endtask

  task automatic test_interval_math();
    // borrow, zero-length interval, then a plain one
    send_cmd(FUNC_START, 5'd1, 32'd10, 30'd500000000);
    send_cmd(FUNC_STOP, 5'd1, 32'd12, 30'd200000000);
    send_cmd(FUNC_START, 5'd1, 32'd20, 30'd0);
    send_cmd(FUNC_STOP, 5'd1, 32'd20, 30'd0);
    send_cmd(FUNC_START, 5'd1, 32'd30, 30'd100);
    send_cmd(FUNC_STOP, 5'd1, 32'd35, NS_MAX);
    send_cmd(FUNC_READ, 5'd1, 32'd99, 30'd1);
  endtask

  task automatic test_misuse();
    send_cmd(FUNC_START, 5'd2, 32'd5, 30'd5);
    send_cmd(FUNC_START, 5'd2, 32'd6, 30'd6);
    send_cmd(FUNC_STOP, 5'd3, 32'd7, 30'd7);
    send_cmd(FUNC_STOP, 5'd2, 32'd8, 30'd8);
    send_cmd(FUNC_STOP, 5'd2, 32'd9, 30'd9);
  endtask

  task automatic test_nsec_clamp();
    send_cmd(FUNC_START, 5'd4, 32'd7, 30'h3FFF_FFFF);
    send_cmd(FUNC_STOP, 5'd4, 32'd8, 30'd1000000000);
  endtask

  task automatic test_seconds_wrap();
    send_cmd(FUNC_START, 5'd5, 32'hFFFF_FFF0, NS_MAX);
    send_cmd(FUNC_STOP, 5'd5, 32'h0000_0010, 30'd0);
    // clock earlier than the start stamp
    send_cmd(FUNC_START, 5'd6, 32'd100, 30'd0);
    send_cmd(FUNC_STOP, 5'd6, 32'd50, 30'd0);
  endtask

  task automatic test_total_saturation();
    send_cmd(FUNC_START, 5'd7, 32'd0, 30'd0);
    send_cmd(FUNC_STOP, 5'd7, '1, NS_MAX);
    // one more nanosecond carries into a seconds overflow
    send_cmd(FUNC_START, 5'd7, 32'd0, 30'd0);
    send_cmd(FUNC_STOP, 5'd7, 32'd0, 30'd1);
    send_cmd(FUNC_CLEAR, 5'd7, 32'd3, 30'd3);
    send_cmd(FUNC_READ, 5'd7, 32'd4, 30'd4);
  endtask

  task automatic test_random_traffic();
    logic [ID_W-1:0]  id;
    logic [1:0]       fn;
    logic [SEC_W-1:0] s;
    int unsigned      pick;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) gaps_on = 1'b0;
      // a few hot entries so start / stop pairs build up statistics
      if ($urandom_range(0, 9) < 7) id = ID_W'($urandom_range(0, 3));
      else                          id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
      pick = $urandom_range(0, 99);
      if (timer_tbl[id].active)
        fn = (pick < 70) ? FUNC_STOP : (pick < 80) ? FUNC_START :
             (pick < 92) ? FUNC_READ : FUNC_CLEAR;
      else
        fn = (pick < 65) ? FUNC_START : (pick < 75) ? FUNC_STOP :
             (pick < 92) ? FUNC_READ : FUNC_CLEAR;
      s = $urandom();
      if (fn == FUNC_STOP && timer_tbl[id].active && $urandom_range(0, 9) < 8)
        s = timer_tbl[id].start_sec + $urandom_range(0, 3);
      send_cmd(fn, id, s, rand_nsec());
    end
  endtask

  initial begin
    foreach (timer_tbl[k]) timer_tbl[k] = RESET_ENTRY;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_interval_math();
    test_misuse();
    test_nsec_clamp();
    test_seconds_wrap();
    test_total_saturation();
    test_random_traffic();

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d commands over clear/start/stop/read, %0d result beats checked",
             n_beats, n_checked);
    $display("%0d intervals measured, %0d misuse cases flagged", n_measured, n_misuse);
    if (n_fail == 0) begin
      $display("tb_interval_timer_stats_table: done, clean");
    end else begin
      $display("tb_interval_timer_stats_table: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout, %0d results still outstanding", pending_stats.size());
    $display("tb_interval_timer_stats_table: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
sv/itst_pkg.sv
sv/itst_ctrl.sv
sv/itst_dp.sv
sv/interval_timer_stats_table.sv
tb/tb_interval_timer_stats_table.sv
